>>> rtl/core/lpr_pkg.sv
// ============================================================================
// lpr_pkg - shared types and constants for the line pixel rasterizer
// Coordinate width, step codes and the line job passed from the front end
// to the walker through the job queue.
// ============================================================================
package lpr_pkg;

    // Grid coordinates are fixed at six bits
    localparam int COORD_W = 6;

    // Default grid size handed to the top level
    localparam int GRID_SIZE_DEF = 64;

    // Job queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;

    // Two-bit step codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    // Step codes for one line, most significant field first
    typedef struct packed {
        logic [1:0] straight_y;
        logic [1:0] straight_x;
        logic [1:0] diag_y;
        logic [1:0] diag_x;
    } step_dirs_t;

    // One classified line job
    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] major_len;
        logic [COORD_W-1:0] minor_len;
        step_dirs_t         dirs;
    } job_t;

endpackage

>>> rtl/core/lpr_front.sv
// ============================================================================
// lpr_front - line request classifier
// Saturates the endpoints to the grid, orders them by the octant rule and
// works out the major and minor lengths and the step codes of the walk.
// ============================================================================
module lpr_front
    import lpr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    output job_t               job
);

    localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(GRID_SIZE - 1);

    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic               swap;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COORD_W-1:0] x2;
    logic [COORD_W-1:0] y2;
    logic [COORD_W-1:0] aw;
    logic [COORD_W-1:0] ah;
    logic               h_neg;
    logic               major_x;
    logic [1:0]         ddx;
    logic [1:0]         ddy;

    // Saturate coordinates that lie off the grid
    assign ax = (start_x > MAX_COORD) ? MAX_COORD : start_x;
    assign ay = (start_y > MAX_COORD) ? MAX_COORD : start_y;
    assign bx = (end_x   > MAX_COORD) ? MAX_COORD : end_x;
    assign by = (end_y   > MAX_COORD) ? MAX_COORD : end_y;

    // Octant rule: every case of it comes down to a negative x delta
    assign swap = (bx < ax);
    assign x1   = swap ? bx : ax;
    assign y1   = swap ? by : ay;
    assign x2   = swap ? ax : bx;
    assign y2   = swap ? ay : by;

    // Deltas after ordering; x never runs backwards here
    assign aw    = x2 - x1;
    assign h_neg = (y2 < y1);
    assign ah    = h_neg ? (y1 - y2) : (y2 - y1);

    // Diagonal step codes
    assign ddx = (aw != '0) ? DIR_POS : DIR_NONE;
    always_comb
    begin
        if (ah == '0)
            ddy = DIR_NONE;
        else if (h_neg)
            ddy = DIR_NEG;
        else
            ddy = DIR_POS;
    end

    // Pick the major axis; a tie goes to y
    assign major_x = (aw > ah);

    always_comb
    begin
        job.start_x       = x1;
        job.start_y       = y1;
        job.major_len     = major_x ? aw : ah;
        job.minor_len     = major_x ? ah : aw;
        job.dirs.diag_x   = ddx;
        job.dirs.diag_y   = ddy;
        job.dirs.straight_x = major_x ? ddx : DIR_NONE;
        job.dirs.straight_y = major_x ? DIR_NONE : ddy;
    end

endmodule

>>> rtl/core/lpr_queue.sv
// ============================================================================
// lpr_queue - job queue between classifier and walker
// Small register FIFO that lets the front end take new requests while the
// walker is still emitting the cells of an earlier line.
// ============================================================================
module lpr_queue
    import lpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Track the fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // Advance pointers and hold the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Fill level never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("lpr_queue: count above depth");

    // Pointers stay apart by exactly the fill level
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (count_reg == FULL_CNT) || (wr_ptr_reg != rd_ptr_reg))
        else $error("lpr_queue: pointers disagree with count");

endmodule

>>> rtl/core/lpr_walker.sv
// ============================================================================
// lpr_walker - Bresenham walk engine
// Takes a queued job and emits one cell per cycle unless out_ready stalls,
// into an output register; on the flagged last cell it loads the next job.
// ============================================================================
module lpr_walker
    import lpr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic               last_pixel
);

    localparam int STEP_W = COORD_W + 1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_x_next;
    logic [COORD_W-1:0] cur_y_reg;
    logic [COORD_W-1:0] cur_y_next;
    logic [STEP_W-1:0]  err_acc_reg;
    logic [STEP_W-1:0]  err_acc_next;
    logic [STEP_W-1:0]  steps_left_reg;
    logic [STEP_W-1:0]  steps_left_next;
    logic [COORD_W-1:0] major_len_reg;
    logic [COORD_W-1:0] major_len_next;
    logic [COORD_W-1:0] minor_len_reg;
    logic [COORD_W-1:0] minor_len_next;
    step_dirs_t         dirs_reg;
    step_dirs_t         dirs_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COORD_W-1:0] pixel_x_reg;
    logic [COORD_W-1:0] pixel_x_next;
    logic [COORD_W-1:0] pixel_y_reg;
    logic [COORD_W-1:0] pixel_y_next;
    logic               last_reg;
    logic               last_next;

    logic               fire;
    logic               is_last;
    logic               load;
    logic [STEP_W-1:0]  err_sum;
    logic               diag;

    // Apply a step code to a coordinate
    function automatic logic [COORD_W-1:0] step_coord(
        input logic [COORD_W-1:0] coord,
        input logic [1:0]         code
    );
        return coord + {{(COORD_W-2){code[1]}}, code};
    endfunction

    assign fire      = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign is_last   = (steps_left_reg == STEP_W'(1));
    assign load      = job_valid && ((state_reg == ST_IDLE) || (fire && is_last));
    assign job_ready = load;

    // Error term update for one step
    assign err_sum = err_acc_reg + {1'b0, minor_len_reg};
    assign diag    = (err_sum >= {1'b0, major_len_reg});

    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        err_acc_next    = err_acc_reg;
        steps_left_next = steps_left_reg;
        major_len_next  = major_len_reg;
        minor_len_next  = minor_len_reg;
        dirs_next       = dirs_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        last_next       = last_reg;

        // Emit the current cell and advance the walk
        if (fire)
        begin
            out_valid_next  = 1'b1;
            pixel_x_next    = cur_x_reg;
            pixel_y_next    = cur_y_reg;
            last_next       = is_last;
            steps_left_next = steps_left_reg - STEP_W'(1);
            if (diag)
            begin
                err_acc_next = err_sum - {1'b0, major_len_reg};
                cur_x_next   = step_coord(cur_x_reg, dirs_reg.diag_x);
                cur_y_next   = step_coord(cur_y_reg, dirs_reg.diag_y);
            end
            else
            begin
                err_acc_next = err_sum;
                cur_x_next   = step_coord(cur_x_reg, dirs_reg.straight_x);
                cur_y_next   = step_coord(cur_y_reg, dirs_reg.straight_y);
            end
            if (is_last)
                state_next = ST_IDLE;
        end

        // Load a fresh job from the queue
        if (load)
        begin
            state_next      = ST_RUN;
            cur_x_next      = job.start_x;
            cur_y_next      = job.start_y;
            major_len_next  = job.major_len;
            minor_len_next  = job.minor_len;
            dirs_next       = job.dirs;
            err_acc_next    = {2'b00, job.major_len[COORD_W-1:1]};
            steps_left_next = {1'b0, job.major_len} + STEP_W'(1);
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            err_acc_reg    <= '0;
            steps_left_reg <= '0;
            major_len_reg  <= '0;
            minor_len_reg  <= '0;
            dirs_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pixel_x_reg    <= '0;
            pixel_y_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            err_acc_reg    <= err_acc_next;
            steps_left_reg <= steps_left_next;
            major_len_reg  <= major_len_next;
            minor_len_reg  <= minor_len_next;
            dirs_reg       <= dirs_next;
            out_valid_reg  <= out_valid_next;
            pixel_x_reg    <= pixel_x_next;
            pixel_y_reg    <= pixel_y_next;
            last_reg       <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign last_pixel = last_reg;

    // A running walk always has cells left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (steps_left_reg != '0))
        else $error("lpr_walker: running with no cells left");

    // Error term stays below the major length
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (major_len_reg != '0)) |->
            (err_acc_reg < {1'b0, major_len_reg}))
        else $error("lpr_walker: error term out of range");

    // The walk count never exceeds the major length plus one
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (steps_left_reg <= ({1'b0, major_len_reg} + STEP_W'(1))))
        else $error("lpr_walker: cell count beyond line length");

    // A job is only taken when the last cell goes out or the walker is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (state_reg == ST_RUN)) |=> (out_valid_reg && last_reg))
        else $error("lpr_walker: job loaded in mid line");

endmodule

>>> rtl/core/line_pixel_rasterizer.sv
// A request passes through the queue, then the walker's job registers and its
// output register, before the first cell of its line is offered when idle.
// Throughput: a line of major length L gives L+1 cells, 1 to 64, one cell per
// cycle while out_ready holds; back-to-back queued lines follow with no gap.
// Requests queue two deep ahead of the walker.
// Reset (rst_n, asynchronous, active low) empties the queue and idles the walker.
// ============================================================================
// line_pixel_rasterizer - integer Bresenham line rasterizer, all octants
// Front end classifies each request into a line job, a short queue holds
// jobs, and the walker emits every grid cell of the line in walk order.
// ============================================================================
module line_pixel_rasterizer
    import lpr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [COORD_W-1:0] pixel_x,
    output logic [COORD_W-1:0] pixel_y,
    output logic               last_pixel
);

    job_t front_job;
    job_t queue_job;
    logic queue_valid;
    logic queue_ready;

    // Classify the incoming item
    lpr_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .job     (front_job)
    );

    // Hold classified jobs
    lpr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (front_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_job)
    );

    // Walk the line
    lpr_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (queue_valid),
        .job_ready  (queue_ready),
        .job        (queue_job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

>>> verif/lpr_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// lpr_checker - line cell predictor and scoreboard
// Watches the request and cell channels of the line pixel rasterizer. Each
// accepted request is walked into its expected grid cells, which are then
// compared in order against the cells the block hands out.
// ============================================================================
module lpr_checker
    import lpr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    input  logic               last_pixel,
    output int                 mismatches,
    output int                 cells_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } grid_pixel_t;

    grid_pixel_t expected_pixels[$];

    // Encode a unit step as a two-bit direction code
    function automatic logic [1:0] dir_of(input int s);
        if (s > 0)
            return DIR_POS;
        else if (s < 0)
            return DIR_NEG;
        return DIR_NONE;
    endfunction

    // Decode a two-bit direction code back to a unit step
    function automatic int step_of(input logic [1:0] code);
        if (code == DIR_POS)
            return 1;
        else if (code == DIR_NEG)
            return -1;
        return 0;
    endfunction

    // Saturate a coordinate onto the grid
    function automatic int clamp_coord(input logic [COORD_W-1:0] v);
        int c;
        c = int'(v);
        if (c > GRID_SIZE - 1)
            c = GRID_SIZE - 1;
        return c;
    endfunction

    // Classify one request and queue every cell of its walk
    task automatic rasterize_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                  input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        int ax, ay, bx, by, dx, dy, slope;
        int x1, y1, x2, y2, w, h, aw, ah, lng, sht;
        bit swap;
        step_dirs_t dirs;
        logic [COORD_W-1:0] cx, cy, major, minor;
        logic [COORD_W:0] err;
        grid_pixel_t px;
        ax = clamp_coord(sx);
        ay = clamp_coord(sy);
        bx = clamp_coord(ex);
        by = clamp_coord(ey);
        dx = bx - ax;
        dy = by - ay;
        slope = (dx != 0) ? dy / dx : 0;
        swap = (dx < 0 && slope == 1) || (dy < 0 && slope > 1) ||
               (dy > 0 && slope < -1) || (dx < 0 && slope >= -1 && slope <= 0);
        x1 = swap ? bx : ax;
        y1 = swap ? by : ay;
        x2 = swap ? ax : bx;
        y2 = swap ? ay : by;
        w = x2 - x1;
        h = y2 - y1;
        aw = (w < 0) ? -w : w;
        ah = (h < 0) ? -h : h;
        dirs.diag_x = dir_of(w);
        dirs.diag_y = dir_of(h);
        // A tie makes y the major axis
        if (aw > ah)
        begin
            lng = aw;
            sht = ah;
            dirs.straight_x = dir_of(w);
            dirs.straight_y = DIR_NONE;
        end
        else
        begin
            lng = ah;
            sht = aw;
            dirs.straight_x = DIR_NONE;
            dirs.straight_y = dir_of(h);
        end
        cx = COORD_W'(x1);
        cy = COORD_W'(y1);
        major = COORD_W'(lng);
        minor = COORD_W'(sht);
        err = {1'b0, major} >> 1;
        for (int n = 0; n <= lng; n++)
        begin
            px.x = cx;
            px.y = cy;
            px.last = (n == lng);
            expected_pixels.push_back(px);
            err = err + {1'b0, minor};
            if (err >= {1'b0, major})
            begin
                err = err - {1'b0, major};
                cx = COORD_W'(int'(cx) + step_of(dirs.diag_x));
                cy = COORD_W'(int'(cy) + step_of(dirs.diag_y));
            end
            else
            begin
                cx = COORD_W'(int'(cx) + step_of(dirs.straight_x));
                cy = COORD_W'(int'(cy) + step_of(dirs.straight_y));
            end
        end
    endtask

    // Predict on every accepted request, compare on every accepted cell
    always @(posedge clk or negedge rst_n)
    begin
        grid_pixel_t want;
        if (!rst_n)
        begin
            expected_pixels.delete();
            mismatches = 0;
            cells_pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                rasterize_line(start_x, start_y, end_x, end_y);
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected cell x=%0d y=%0d last=%0b",
                                 $time, pixel_x, pixel_y, last_pixel);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (want.x !== pixel_x || want.y !== pixel_y || want.last !== last_pixel)
                    begin
                        if (mismatches < 10)
                            $display("%0t: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                     $time, want.x, want.y, want.last,
                                     pixel_x, pixel_y, last_pixel);
                        mismatches++;
                    end
                end
            end
            cells_pending = expected_pixels.size();
        end
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - regression bench for the line pixel rasterizer
// Drives directed corner lines and then random line requests in bursts,
// stalls the cell output on a changing pattern with one long hold-off, and
// leaves prediction and comparison to the checker beside the block.
// ============================================================================
module tb
    import lpr_pkg::*;
();

    localparam int RANDOM_LINES = 250;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               out_valid;
    logic               out_ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last_pixel;

    int mismatches;
    int cells_pending;
    int cycle_count;
    int burst_left;
    bit hold_arm;

    line_pixel_rasterizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    lpr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .last_pixel    (last_pixel),
        .mismatches    (mismatches),
        .cells_pending (cells_pending)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("line_pixel_rasterizer regression: fail");
            $finish;
        end
    end

    // Stall the cell output on a shifting pattern, with one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        out_ready = 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_arm)
            begin
                hold_arm = 1'b0;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= (cycle_count % 5 != 0);
                endcase
            end
        end
    end

    // Offer one line request and hold it until accepted
    task automatic offer_line(input int x0, input int y0, input int x1, input int y1);
        in_valid <= 1'b1;
        start_x <= COORD_W'(x0);
        start_y <= COORD_W'(y0);
        end_x <= COORD_W'(x1);
        end_y <= COORD_W'(y1);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send a line, then idle for a random gap once the burst runs out
    task automatic send_line(input int x0, input int y0, input int x1, input int y1);
        offer_line(x0, y0, x1, y1);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > 63)
            return 63;
        return v;
    endfunction

    // Stimulus and verdict
    initial
    begin
        int x0, y0, x1, y1, kind, d;
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        hold_arm = 1'b0;
        cycle_count = 0;
        burst_left = 4;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners, axes and each swap rule
        send_line(0, 0, 0, 0);
        send_line(63, 63, 63, 63);
        send_line(0, 0, 63, 63);
        send_line(63, 63, 0, 0);
        send_line(0, 63, 63, 0);
        send_line(63, 0, 0, 63);
        send_line(0, 5, 63, 5);
        send_line(63, 5, 0, 5);
        send_line(5, 0, 5, 63);
        send_line(5, 63, 5, 0);
        send_line(40, 40, 20, 18);
        send_line(30, 50, 20, 10);
        send_line(30, 10, 20, 50);
        send_line(50, 10, 10, 20);
        send_line(50, 10, 10, 50);
        send_line(0, 0, 10, 10);
        send_line(0, 0, 63, 1);
        send_line(0, 0, 1, 63);
        send_line(63, 0, 0, 1);
        send_line(1, 63, 0, 0);
        send_line(42, 21, 21, 42);
        send_line(12, 30, 50, 29);

        // Random lines, mostly short, with one long output hold-off
        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            if (i == 80)
                hold_arm = 1'b1;
            kind = $urandom_range(0, 7);
            x0 = $urandom_range(0, 63);
            y0 = $urandom_range(0, 63);
            d = (kind < 2) ? 3 : 12;
            if (kind < 5)
            begin
                x1 = clip_coord(x0 + $urandom_range(0, 2 * d) - d);
                y1 = clip_coord(y0 + $urandom_range(0, 2 * d) - d);
            end
            else if (kind == 5)
            begin
                x1 = $urandom_range(0, 1) ? x0 : $urandom_range(0, 63);
                y1 = (x1 == x0) ? $urandom_range(0, 63) : y0;
            end
            else if (kind == 6)
            begin
                d = $urandom_range(0, 20);
                x1 = clip_coord($urandom_range(0, 1) ? x0 + d : x0 - d);
                y1 = clip_coord($urandom_range(0, 1) ? y0 + d : y0 - d);
            end
            else
            begin
                x1 = $urandom_range(0, 63);
                y1 = $urandom_range(0, 63);
            end
            send_line(x0, y0, x1, y1);
        end
        in_valid <= 1'b0;

        // Drain outstanding cells
        while (cells_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && cells_pending == 0)
            $display("line_pixel_rasterizer regression: pass");
        else
            $display("line_pixel_rasterizer regression: fail");
        $finish;
    end

endmodule

>>> line_pixel_rasterizer.f
rtl/core/lpr_pkg.sv
rtl/core/lpr_front.sv
rtl/core/lpr_queue.sv
rtl/core/lpr_walker.sv
rtl/core/line_pixel_rasterizer.sv
verif/lpr_checker.sv
verif/tb.sv
